// ----- rtl/cdr_pkg.sv -----
// Package for the calendar date register: word types, codes, constants and calendar helpers.
package cdr_pkg;

  localparam int YEAR_BITS = 14;
  localparam int ADD_BITS  = 12;
  localparam int SUM_BITS  = ADD_BITS + 1;

  localparam logic [YEAR_BITS-1:0] MIN_YEAR = YEAR_BITS'(1900);
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  // Exact divisibility by 25: multiply by the inverse of 25 modulo 2^32 and
  // compare against floor((2^32-1)/25).
  localparam logic [31:0] INV25 = 32'hC28F_5C29;
  localparam logic [31:0] LIM25 = 32'h0A3D_70A3;

  typedef enum logic [2:0] {
    CMD_SET_DATE  = 3'd0,
    CMD_SET_MONTH = 3'd1,
    CMD_SET_DAY   = 3'd2,
    CMD_SET_YEAR  = 3'd3,
    CMD_ADD_DAYS  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_WALK,
    S_TALLY_INIT,
    S_TALLY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]           command;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [YEAR_BITS-1:0] year;
    logic [ADD_BITS-1:0]  day_count;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [3:0]           cur_month;
    logic [4:0]           cur_day;
    logic [YEAR_BITS-1:0] cur_year;
    logic                 is_leap;
    logic [4:0]           month_length;
    logic [8:0]           day_of_year;
    logic [8:0]           days_remaining;
  } rsp_t;

  function automatic logic leap_of(input logic [YEAR_BITS-1:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = {{(32-YEAR_BITS){1'b0}}, y} * INV25;
    div25 = (prod <= LIM25);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Out-of-range months read as 31 days.
  function automatic logic [4:0] len_of(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd2:    l = leap ? 5'd29 : 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

  function automatic logic month_ok(input logic [3:0] m);
    return (m >= 4'd1) && (m <= 4'd12);
  endfunction

endpackage

// ----- rtl/calendar_date_register.sv -----
// Top level of the calendar date register: command sequencer, date walker and report builder.
//
// Usage
//   One command word enters on the req channel (req_valid/req_ready) and one
//   result word leaves on the rsp channel (rsp_valid/rsp_ready) for each.
//   Commands: set date, set month, set day, set year and add days.
//   The block works on one command at a time; req_ready is high only while
//   the sequencer is idle.
// Sequence
//   Every command passes through the check, apply and tally-init steps, then
//   tallies the lengths of the months before the held one into the day of
//   year, and ends in the finish step. Add days with a nonzero count also walks
//   one month per cycle through a single month-length and compare unit between
//   apply and tally-init. No new command is taken until its result is loaded.
//   The leap flag comes from one shared multiply-and-compare unit, registered.
// Reset
//   rst (synchronous) loads January 1 of year 0, meaning no year is held,
//   and empties the result register.
// Stall
//   The result register holds its word until rsp_ready; a new command may be
//   accepted meanwhile, and its result waits in the final step until the
//   register is free.
module calendar_date_register (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cdr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cdr_pkg::rsp_t rsp
);
  import cdr_pkg::*;

  state_t state, state_next;

  req_t                 op;
  logic                 op_leap;
  logic                 leap_reg;
  logic [3:0]           month_reg;
  logic [4:0]           day_reg;
  logic [YEAR_BITS-1:0] year_reg;
  logic [ADD_BITS-1:0]  count;
  status_t              status_q;
  logic [3:0]           tally_idx;
  logic [8:0]           doy;

  // control decoded from the state and the result handshake
  logic                 leap_sel_op;
  logic                 rsp_load;

  // shared leap unit
  logic [YEAR_BITS-1:0] leap_year;
  logic                 leap_val;

  // apply step
  logic                 held;
  logic [4:0]           len_op;
  logic [4:0]           len_held_new;
  logic [4:0]           len_cur;
  logic [4:0]           len_cur_op;
  logic                 date_ok;

  // walk, tally and report steps
  logic [SUM_BITS-1:0]  walk_sum;
  logic                 walk_fits;
  logic [4:0]           walk_step;
  logic [4:0]           tally_len;
  logic [8:0]           year_total;

  assign held = (year_reg >= MIN_YEAR);

  // Feed the operand year during the check step, the held year otherwise.
  assign leap_year = leap_sel_op ? op.year : year_reg;
  assign leap_val  = leap_of(leap_year);

  assign len_op       = len_of(op.month, op_leap);
  assign len_held_new = len_of(op.month, leap_reg);
  assign len_cur      = len_of(month_reg, leap_reg);
  assign len_cur_op   = len_of(month_reg, op_leap);
  assign date_ok      = month_ok(op.month) && (op.year >= MIN_YEAR) &&
                        (op.day != 5'd0) && (op.day <= len_op);

  assign walk_sum  = SUM_BITS'(day_reg) + SUM_BITS'(count);
  assign walk_fits = (walk_sum <= SUM_BITS'(len_cur));
  assign walk_step = len_cur - day_reg + 5'd1;

  assign tally_len  = len_of(tally_idx, leap_reg);
  assign year_total = leap_reg ? 9'd366 : 9'd365;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: state_next = S_APPLY;
      S_APPLY: begin
        if ((op.command == CMD_ADD_DAYS) && (op.day_count != '0)) begin
          state_next = S_WALK;
        end else begin
          state_next = S_TALLY_INIT;
        end
      end
      S_WALK: begin
        if (walk_fits) begin
          state_next = S_TALLY_INIT;
        end else if ((month_reg == 4'd12) && (year_reg >= YEAR_MAX)) begin
          state_next = S_TALLY_INIT;
        end else if (count == ADD_BITS'(walk_step)) begin
          state_next = S_TALLY_INIT;
        end
      end
      S_TALLY_INIT: state_next = S_TALLY;
      S_TALLY: begin
        if (tally_idx >= month_reg) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_ready   = (state == S_IDLE);
    leap_sel_op = (state == S_CHECK);
    rsp_load    = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      month_reg <= 4'd1;
      day_reg   <= 5'd1;
      year_reg  <= '0;
      leap_reg  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Register the leap flag of the held year, except during the check step.
      if (!leap_sel_op) leap_reg <= leap_val;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_APPLY: begin
          case (op.command)
            CMD_SET_DATE: begin
              if (date_ok) begin
                month_reg <= op.month;
                day_reg   <= op.day;
                year_reg  <= op.year;
              end
            end
            CMD_SET_MONTH: begin
              if (month_ok(op.month) && held) begin
                month_reg <= op.month;
                if (day_reg > len_held_new) day_reg <= len_held_new;
              end
            end
            CMD_SET_DAY: begin
              if ((op.day != 5'd0) && held) begin
                day_reg <= (op.day > len_cur) ? len_cur : op.day;
              end
            end
            CMD_SET_YEAR: begin
              if (op.year >= MIN_YEAR) begin
                year_reg <= op.year;
                if (day_reg > len_cur_op) day_reg <= len_cur_op;
              end
            end
            default: begin
            end
          endcase
        end
        S_WALK: begin
          // Advance one month per cycle, finish inside the current one, or saturate at December 31 of YEAR_MAX.
          if (walk_fits) begin
            day_reg <= walk_sum[4:0];
          end else if (month_reg == 4'd12) begin
            if (year_reg >= YEAR_MAX) begin
              day_reg  <= 5'd31;
              year_reg <= YEAR_MAX;
            end else begin
              day_reg   <= 5'd1;
              month_reg <= 4'd1;
              year_reg  <= year_reg + YEAR_BITS'(1);
            end
          end else begin
            day_reg   <= 5'd1;
            month_reg <= month_reg + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload, working and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= req;
      end
      S_CHECK: begin
        op_leap <= leap_val;
      end
      S_APPLY: begin
        count <= op.day_count;
        case (op.command)
          CMD_SET_DATE:  status_q <= date_ok ? ST_DONE : ST_REJECTED;
          CMD_SET_MONTH: status_q <= (month_ok(op.month) && held) ? ST_DONE : ST_REJECTED;
          CMD_SET_DAY:   status_q <= ((op.day != 5'd0) && held) ? ST_DONE : ST_REJECTED;
          CMD_SET_YEAR:  status_q <= (op.year >= MIN_YEAR) ? ST_DONE : ST_REJECTED;
          CMD_ADD_DAYS:  status_q <= ST_DONE;
          default:       status_q <= ST_REJECTED;
        endcase
      end
      S_WALK: begin
        if (walk_fits) begin
          count <= '0;
        end else begin
          count <= count - ADD_BITS'(walk_step);
          if ((month_reg == 4'd12) && (year_reg >= YEAR_MAX)) status_q <= ST_SATURATED;
        end
      end
      S_TALLY_INIT: begin
        doy       <= 9'(day_reg);
        tally_idx <= 4'd1;
      end
      S_TALLY: begin
        // Add the length of each month before the held one.
        if (tally_idx < month_reg) begin
          doy       <= doy + 9'(tally_len);
          tally_idx <= tally_idx + 4'd1;
        end
      end
      default: begin
      end
    endcase

    if (rsp_load) begin
      rsp.status         <= status_q;
      rsp.cur_month      <= month_reg;
      rsp.cur_day        <= day_reg;
      rsp.cur_year       <= year_reg;
      rsp.is_leap        <= leap_reg;
      rsp.month_length   <= len_cur;
      rsp.day_of_year    <= doy;
      rsp.days_remaining <= (doy <= year_total) ? (year_total - doy) : 9'd0;
    end
  end

endmodule
